// File: hdl/matrix_saddle_point_search_assert.svh
// Assertion macros shared by the saddle-point search RTL.
`ifndef MATRIX_SADDLE_POINT_SEARCH_ASSERT_SVH
`define MATRIX_SADDLE_POINT_SEARCH_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define MSPS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("msps: invariant violated");

// A consequence that must hold in the same cycle as its antecedent.
`define MSPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msps: same-cycle implication violated");

// A consequence that must hold in the cycle after its antecedent.
`define MSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msps: next-cycle implication violated");

`endif

// File: hdl/msps_pkg.sv
// Package with the widths, limits, register indexes and helpers of the saddle-point search.
package msps_pkg;

    // Matrix size limits.
    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;
    localparam int DIM_CAP  = 16;
    localparam int ROW_CAP  = (MAX_ROWS < DIM_CAP) ? MAX_ROWS : DIM_CAP;
    localparam int COL_CAP  = (MAX_COLS < DIM_CAP) ? MAX_COLS : DIM_CAP;

    // Element store geometry.
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths.
    localparam int VAL_W  = 16;
    localparam int IDX_W  = 4;
    localparam int DIM_W  = 5;
    localparam int CNT_W  = 9;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register reset values.
    localparam logic [DIM_W-1:0] ROW_COUNT_RST = 5'd4;
    localparam logic [DIM_W-1:0] COL_COUNT_RST = 5'd4;

    // Register indexes, taken from paddr[2].
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // A zero dimension acts as one; a large one saturates to the cap.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > cap) begin
            res = cap;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: hdl/msps_if.sv
// Valid/ready channel interfaces for matrix elements and search results.
interface msps_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [msps_pkg::VAL_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface msps_out_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic        [msps_pkg::IDX_W-1:0] row_index;
    logic        [msps_pkg::IDX_W-1:0] col_index;
    logic signed [msps_pkg::VAL_W-1:0] element_out;
    logic                              last;

    modport source (output valid, output found, output row_index, output col_index,
                    output element_out, output last, input ready);
    modport sink   (input valid, input found, input row_index, input col_index,
                    input element_out, input last, output ready);
endinterface

// File: hdl/msps_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module msps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/matrix_saddle_point_search.sv
// Top level of the matrix saddle-point search: loader, row/column scanner and result queue.
//
// Usage: matrix elements arrive on i_elem, one item per element in row-major order,
// and are written to the element RAM at one item per cycle. The item that brings the
// load count to row_count * col_count starts the search; i_elem.ready stays low until
// the search has handed its final result to the output register. row_count and
// col_count are written over the APB port (byte addresses 0 and 4); the user must
// write them only while idle, which the block itself does not enforce. Each row
// finds its maximum with col_count reads through the one RAM read port, then reads
// row_count elements to check that column, then closes the row. Results leave on
// o_res with valid/ready; a saddle element is held until the next one or the end
// of the run so the last result of the run can carry last = 1, and a run without
// one yields a single not-found item. When the receiver stalls the output register
// holds and the scan waits at the next result to be queued; loading of the next
// matrix can start while the final result still waits. Synchronous reset clears
// the load count, the registers (4 by 4), the sequencer state and the valid flags;
// the RAM content is not cleared and needs no clearing pass.
module matrix_saddle_point_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    msps_in_if.sink                       i_elem,
    msps_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msps_pkg::APB_AW-1:0]   paddr,
    input  logic [msps_pkg::APB_DW-1:0]   pwdata,
    output logic [msps_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    `include "matrix_saddle_point_search_assert.svh"

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_ROW  = 5'b00010,
        S_COL  = 5'b00100,
        S_NEXT = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    // Configuration registers.
    logic [msps_pkg::DIM_W-1:0] r_row_count;
    logic [msps_pkg::DIM_W-1:0] r_col_count;

    // Control state.
    t_state                      r_state,    n_state;
    logic [msps_pkg::CNT_W-1:0]  r_load_cnt, n_load_cnt;
    logic [msps_pkg::IDX_W-1:0]  r_i,        n_i;
    logic [msps_pkg::IDX_W-1:0]  r_j,        n_j;
    logic                        r_iss_done, n_iss_done;
    logic [msps_pkg::ADDR_W-1:0] r_base,     n_base;
    logic [msps_pkg::ADDR_W-1:0] r_caddr,    n_caddr;
    logic                        r_tag_v;
    logic                        r_tag_first;
    logic                        r_tag_last;
    logic [msps_pkg::IDX_W-1:0]  r_tag_j;
    logic                        r_ok,       n_ok;
    logic signed [msps_pkg::VAL_W-1:0] r_best, n_best;
    logic [msps_pkg::IDX_W-1:0]  r_bc,       n_bc;

    // Held result and output register.
    logic                        r_pend_v,   n_pend_v;
    logic [msps_pkg::IDX_W-1:0]  r_pend_row, n_pend_row;
    logic [msps_pkg::IDX_W-1:0]  r_pend_col, n_pend_col;
    logic signed [msps_pkg::VAL_W-1:0] r_pend_val, n_pend_val;
    logic                        r_out_v,    n_out_v;
    logic                        r_out_found, n_out_found;
    logic [msps_pkg::IDX_W-1:0]  r_out_row,  n_out_row;
    logic [msps_pkg::IDX_W-1:0]  r_out_col,  n_out_col;
    logic signed [msps_pkg::VAL_W-1:0] r_out_val, n_out_val;
    logic                        r_out_last, n_out_last;

    // Derived values.
    logic [msps_pkg::DIM_W-1:0]  rows;
    logic [msps_pkg::DIM_W-1:0]  cols;
    logic [msps_pkg::CNT_W-1:0]  total;
    logic [msps_pkg::CNT_W-1:0]  cnt_inc;
    logic                        in_acc;
    logic                        out_free;
    logic                        cfg_we;
    logic                        rd_en;
    logic [msps_pkg::ADDR_W-1:0] rd_addr;
    logic [msps_pkg::VAL_W-1:0]  rd_data;
    logic signed [msps_pkg::VAL_W-1:0] rd_val;
    logic                        issue_last;

    // Effective dimensions and matrix size.
    assign rows    = msps_pkg::clamp_dim(r_row_count, msps_pkg::DIM_W'(msps_pkg::ROW_CAP));
    assign cols    = msps_pkg::clamp_dim(r_col_count, msps_pkg::DIM_W'(msps_pkg::COL_CAP));
    assign total   = msps_pkg::CNT_W'(rows) * msps_pkg::CNT_W'(cols);
    assign cnt_inc = r_load_cnt + 1'b1;

    // Handshakes.
    assign i_elem.ready = (r_state == S_LOAD);
    assign in_acc       = i_elem.valid && (r_state == S_LOAD);
    assign out_free     = !r_out_v || o_res.ready;

    // APB register port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            msps_pkg::REG_ROW_COUNT: prdata = msps_pkg::APB_DW'(r_row_count);
            msps_pkg::REG_COL_COUNT: prdata = msps_pkg::APB_DW'(r_col_count);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= msps_pkg::ROW_COUNT_RST;
            r_col_count <= msps_pkg::COL_COUNT_RST;
        end else if (cfg_we) begin
            case (paddr[2])
                msps_pkg::REG_ROW_COUNT: r_row_count <= pwdata[msps_pkg::DIM_W-1:0];
                msps_pkg::REG_COL_COUNT: r_col_count <= pwdata[msps_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Element store: writes while loading, one read per cycle while scanning.
    assign rd_en      = ((r_state == S_ROW) || (r_state == S_COL)) && !r_iss_done;
    assign rd_addr    = (r_state == S_ROW) ? (r_base + msps_pkg::ADDR_W'(r_j)) : r_caddr;
    assign issue_last = (r_state == S_ROW) ? ({1'b0, r_j} == cols - 1'b1)
                                           : ({1'b0, r_j} == rows - 1'b1);
    assign rd_val     = $signed(rd_data);

    msps_ram #(
        .WIDTH (msps_pkg::VAL_W),
        .DEPTH (msps_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_load_cnt[msps_pkg::ADDR_W-1:0]),
        .i_wdata (i_elem.element_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Sequencer: load, row maximum, column check, queue result, finish.
    always_comb begin
        n_state     = r_state;
        n_load_cnt  = r_load_cnt;
        n_i         = r_i;
        n_j         = r_j;
        n_iss_done  = r_iss_done;
        n_base      = r_base;
        n_caddr     = r_caddr;
        n_ok        = r_ok;
        n_best      = r_best;
        n_bc        = r_bc;
        n_pend_v    = r_pend_v;
        n_pend_row  = r_pend_row;
        n_pend_col  = r_pend_col;
        n_pend_val  = r_pend_val;
        n_out_v     = r_out_v && !o_res.ready;
        n_out_found = r_out_found;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;

        // Read issue counter shared by both scans.
        if (rd_en) begin
            n_j = r_j + 1'b1;
            if (issue_last) begin
                n_iss_done = 1'b1;
            end
        end

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    n_load_cnt = cnt_inc;
                    if (cnt_inc >= total) begin
                        n_load_cnt = '0;
                        n_state    = S_ROW;
                        n_i        = '0;
                        n_j        = '0;
                        n_iss_done = 1'b0;
                        n_base     = '0;
                    end
                end
            end
            S_ROW: begin
                // Track the row maximum; the first column wins a tie.
                if (r_tag_v) begin
                    if (r_tag_first || (rd_val > r_best)) begin
                        n_best = rd_val;
                        n_bc   = r_tag_j;
                    end
                    if (r_tag_last) begin
                        n_state    = S_COL;
                        n_j        = '0;
                        n_iss_done = 1'b0;
                        n_ok       = 1'b1;
                        n_caddr    = msps_pkg::ADDR_W'(n_bc);
                    end
                end
                if (rd_en) begin
                    // Column address follows the row.
                end
            end
            S_COL: begin
                if (rd_en) begin
                    n_caddr = r_caddr + msps_pkg::ADDR_W'(cols);
                end
                // Any strictly smaller element in the column disqualifies the row.
                if (r_tag_v) begin
                    if (rd_val < r_best) begin
                        n_ok = 1'b0;
                    end
                    if (r_tag_last) begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                // A new saddle element pushes the held one out first.
                if (!(r_ok && r_pend_v) || out_free) begin
                    if (r_ok && r_pend_v) begin
                        n_out_v     = 1'b1;
                        n_out_found = 1'b1;
                        n_out_row   = r_pend_row;
                        n_out_col   = r_pend_col;
                        n_out_val   = r_pend_val;
                        n_out_last  = 1'b0;
                    end
                    if (r_ok) begin
                        n_pend_v   = 1'b1;
                        n_pend_row = r_i;
                        n_pend_col = r_bc;
                        n_pend_val = r_best;
                    end
                    if ({1'b0, r_i} == rows - 1'b1) begin
                        n_state = S_FIN;
                    end else begin
                        n_state    = S_ROW;
                        n_i        = r_i + 1'b1;
                        n_j        = '0;
                        n_iss_done = 1'b0;
                        n_base     = r_base + msps_pkg::ADDR_W'(cols);
                    end
                end
            end
            S_FIN: begin
                // Final item of the run: held saddle element or not-found.
                if (out_free) begin
                    n_out_v     = 1'b1;
                    n_out_found = r_pend_v;
                    n_out_row   = r_pend_v ? r_pend_row : '0;
                    n_out_col   = r_pend_v ? r_pend_col : '0;
                    n_out_val   = r_pend_v ? r_pend_val : '0;
                    n_out_last  = 1'b1;
                    n_pend_v    = 1'b0;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_iss_done <= 1'b1;
            r_tag_v    <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_iss_done <= n_iss_done;
            r_tag_v    <= rd_en;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_base      <= n_base;
        r_caddr     <= n_caddr;
        r_ok        <= n_ok;
        r_best      <= n_best;
        r_bc        <= n_bc;
        r_tag_first <= (r_j == '0);
        r_tag_last  <= issue_last;
        r_tag_j     <= r_j;
        r_pend_row  <= n_pend_row;
        r_pend_col  <= n_pend_col;
        r_pend_val  <= n_pend_val;
        r_out_found <= n_out_found;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_val   <= n_out_val;
        r_out_last  <= n_out_last;
    end

    // Result channel.
    assign o_res.valid       = r_out_v;
    assign o_res.found       = r_out_found;
    assign o_res.row_index   = r_out_row;
    assign o_res.col_index   = r_out_col;
    assign o_res.element_out = r_out_val;
    assign o_res.last        = r_out_last;

    // Checks on the sequencer.
    `MSPS_ASSERT_ALWAYS(a_load_cnt_range, i_clk, i_rst_n, r_load_cnt < msps_pkg::CNT_W'(msps_pkg::STORE_DEPTH))
    `MSPS_ASSERT_IMPL(a_read_in_scan, i_clk, i_rst_n, r_tag_v, (r_state == S_ROW) || (r_state == S_COL))
    `MSPS_ASSERT_NEXT(a_held_result_kept, i_clk, i_rst_n, (r_state == S_NEXT) && r_ok && r_pend_v && !out_free, (r_state == S_NEXT) && r_pend_v)
    `MSPS_ASSERT_NEXT(a_final_marked, i_clk, i_rst_n, (r_state == S_FIN) && out_free, (r_state == S_LOAD) && r_out_v && r_out_last && !r_pend_v)

endmodule
